@@ hw/rtl/rut_pkg.sv @@
`default_nettype none
package rut_pkg;

  localparam int unsigned REF_BITS = 16;
  localparam logic [REF_BITS-1:0] REF_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_FOUND   = 3'd0,
    ST_CREATED = 3'd1,
    ST_FULL    = 3'd2,
    ST_KEPT    = 3'd3,
    ST_REMOVED = 3'd4,
    ST_IGNORED = 3'd5,
    ST_BAD     = 3'd6,
    ST_SAT     = 3'd7
  } status_e;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_WT,
    S_WALK_RD,
    S_WALK_WT,
    S_FREE_SCAN,
    S_INS_LINK,
    S_INS_DONE,
    S_REL_RD,
    S_REL_WT,
    S_REL_DEC,
    S_UNL_NEXT,
    S_UNL_PREV,
    S_UNL_PREV_WT,
    S_UNL_FIX,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

@@ hw/rtl/rut_ram.sv @@
`default_nettype none
// single port memory with registered read
module rut_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

@@ hw/rtl/refcounted_uid_table.sv @@
`default_nettype none
// acquire walks the bucket chain, reading each entry passed over, and answers found,
//   saturated, full or created; a create on a non-empty chain also fixes the old head
//   release: ignored or bad without a read, else the entry is read: bad, kept or removed
// one word in flight, busy high from accept to the result, next word taken the cycle after
// after reset a clearing pass over every bucket head and entry runs before start is taken
// the receiver cannot stall: each result word is shown for one cycle on done_o
module refcounted_uid_table
  import rut_pkg::*;
#(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned BUCKETS  = 256,
  parameter int unsigned UID_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation_i,
  input  wire logic [15:0] user_id_i,
  input  wire logic [5:0]  entry_handle_i,
  input  wire logic        handle_present_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [5:0]       result_handle_o,
  output logic [15:0]      ref_count_o
);

  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned PW = EW + 1;   // pointer with null code ENTRIES
  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned CW = (BUCKETS > ENTRIES) ? BW + 1 : EW + 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);
  localparam int unsigned UW = (UID_BITS < 16) ? UID_BITS : 16;
  // entry word: valid, user, refs, next, prev
  localparam int unsigned RW = 1 + UW + REF_BITS + 2 * PW;

  typedef struct packed {
    logic                valid;
    logic [UW-1:0]       user;
    logic [REF_BITS-1:0] refs;
    logic [PW-1:0]       next;
    logic [PW-1:0]       prev;
  } entry_t;

  state_e state_q, state_d;

  // bucket head memory
  logic          bh_we;
  logic [BW-1:0] bh_addr;
  logic [PW-1:0] bh_wdata, bh_rdata;
  // entry memory
  logic          en_we;
  logic [EW-1:0] en_addr;
  entry_t        en_wdata, en_rdata;

  rut_ram #(.DEPTH(BUCKETS), .WIDTH(PW)) u_heads (
    .clk_i, .we_i(bh_we), .addr_i(bh_addr), .wdata_i(bh_wdata), .rdata_o(bh_rdata)
  );
  rut_ram #(.DEPTH(ENTRIES), .WIDTH(RW)) u_entries (
    .clk_i, .we_i(en_we), .addr_i(en_addr), .wdata_i(en_wdata), .rdata_o(en_rdata)
  );

  // small allocation bitmap, one flip-flop per entry
  logic [ENTRIES-1:0] used_q, used_d;

  logic [CW-1:0]       cnt_q, cnt_d;       // clear sweep, walk steps
  logic [UW-1:0]       uid_q, uid_d;
  logic [BW-1:0]       bkt_q, bkt_d;
  logic [5:0]          hnd_q, hnd_d;
  logic                hp_q, hp_d;
  logic [PW-1:0]       cur_q, cur_d;       // walk pointer or entry being handled
  logic [PW-1:0]       head_q, head_d;     // old chain head on insert
  entry_t              ent_q, ent_d;       // copy of entry under release
  logic                res_v_q, res_v_d;
  logic [2:0]          st_q, st_d;
  logic [5:0]          rh_q, rh_d;
  logic [15:0]         rc_q, rc_d;

  // hash of the uid held in the command
  function automatic logic [BW-1:0] hash_f(input logic [UW-1:0] u);
    logic [UW-1:0] x;
    x = (u >> 8) ^ u;
    return BW'(x % BUCKETS);
  endfunction

  // lowest clear bit of the bitmap
  logic          free_any;
  logic [EW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_any = 1'b1;
        free_idx = EW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      used_q  <= {{(ENTRIES-1){1'b0}}, 1'b1};
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    uid_q  <= uid_d;
    bkt_q  <= bkt_d;
    hnd_q  <= hnd_d;
    hp_q   <= hp_d;
    cur_q  <= cur_d;
    head_q <= head_d;
    ent_q  <= ent_d;
    st_q   <= st_d;
    rh_q   <= rh_d;
    rc_q   <= rc_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    used_d   = used_q;
    uid_d    = uid_q;
    bkt_d    = bkt_q;
    hnd_d    = hnd_q;
    hp_d     = hp_q;
    cur_d    = cur_q;
    head_d   = head_q;
    ent_d    = ent_q;
    res_v_d  = 1'b0;
    st_d     = st_q;
    rh_d     = rh_q;
    rc_d     = rc_q;
    bh_we    = 1'b0;
    bh_addr  = bkt_q;
    bh_wdata = NIL;
    en_we    = 1'b0;
    en_addr  = cur_q[EW-1:0];
    en_wdata = ent_q;
    busy     = 1'b1;

    unique case (state_q)
      // reset pass: all heads null but bucket zero, all entries free but entry zero
      S_CLEAR: begin
        if (cnt_q < CW'(BUCKETS)) begin
          bh_we    = 1'b1;
          bh_addr  = cnt_q[BW-1:0];
          bh_wdata = (cnt_q == '0) ? '0 : NIL;
        end
        if (cnt_q < CW'(ENTRIES)) begin
          en_we          = 1'b1;
          en_addr        = cnt_q[EW-1:0];
          en_wdata.valid = (cnt_q == '0);
          en_wdata.user  = '0;
          en_wdata.refs  = (cnt_q == '0) ? REF_BITS'(1) : '0;
          en_wdata.next  = NIL;
          en_wdata.prev  = NIL;
        end
        if (cnt_q == CW'((BUCKETS > ENTRIES) ? BUCKETS - 1 : ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
        cnt_d = cnt_q + 1'b1;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          uid_d = user_id_i[UW-1:0];
          bkt_d = hash_f(user_id_i[UW-1:0]);
          hnd_d = entry_handle_i;
          hp_d  = handle_present_i;
          cnt_d = '0;
          state_d = (operation_i == OP_ACQUIRE) ? S_HEAD_RD : S_REL_RD;
        end
      end
      S_HEAD_RD: state_d = S_HEAD_WT;
      S_HEAD_WT: begin
        cur_d  = bh_rdata;
        head_d = bh_rdata;
        state_d = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (cur_q >= NIL || cnt_q >= CW'(ENTRIES)) begin
          state_d = S_FREE_SCAN;
        end else begin
          state_d = S_WALK_WT;
        end
      end
      S_WALK_WT: begin
        if (en_rdata.valid && en_rdata.user == uid_q) begin
          rh_d = 6'(cur_q);
          if (en_rdata.refs >= REF_MAX) begin
            st_d = ST_SAT;
            rc_d = REF_MAX;
          end else begin
            ent_d      = en_rdata;
            ent_d.refs = en_rdata.refs + 1'b1;
            en_we      = 1'b1;
            en_wdata   = ent_d;
            st_d = ST_FOUND;
            rc_d = ent_d.refs;
          end
          res_v_d = 1'b1;
          state_d = S_DONE;
        end else begin
          cur_d = en_rdata.next;
          cnt_d = cnt_q + 1'b1;
          state_d = S_WALK_RD;
        end
      end
      S_FREE_SCAN: begin
        if (!free_any) begin
          st_d = ST_FULL; rh_d = '0; rc_d = '0;
          res_v_d = 1'b1;
          state_d = S_DONE;
        end else begin
          cur_d = {1'b0, free_idx};
          used_d[free_idx] = 1'b1;
          en_we          = 1'b1;
          en_addr        = free_idx;
          en_wdata.valid = 1'b1;
          en_wdata.user  = uid_q;
          en_wdata.refs  = REF_BITS'(1);
          en_wdata.next  = head_q;
          en_wdata.prev  = NIL;
          bh_we    = 1'b1;
          bh_wdata = {1'b0, free_idx};
          state_d  = S_INS_LINK;
        end
      end
      // old head gets its prev pointed at the new entry
      S_INS_LINK: begin
        en_addr = head_q[EW-1:0];
        state_d = (head_q < NIL) ? S_INS_DONE : S_INS_DONE;
        if (head_q < NIL) begin
          state_d = S_INS_DONE;
          head_d  = head_q;
        end
        ent_d = en_rdata;
        if (head_q >= NIL) begin
          st_d = ST_CREATED; rh_d = 6'(cur_q); rc_d = 16'd1;
          res_v_d = 1'b1;
          state_d = S_DONE;
        end
      end
      S_INS_DONE: begin
        en_addr        = head_q[EW-1:0];
        en_we          = 1'b1;
        en_wdata       = en_rdata;
        en_wdata.prev  = cur_q;
        st_d = ST_CREATED; rh_d = 6'(cur_q); rc_d = 16'd1;
        res_v_d = 1'b1;
        state_d = S_DONE;
      end
      S_REL_RD: begin
        en_addr = hnd_q[EW-1:0];
        cur_d   = PW'(hnd_q[EW-1:0]);
        if (!hp_q) begin
          st_d = ST_IGNORED; rh_d = '0; rc_d = '0;
          res_v_d = 1'b1;
          state_d = S_DONE;
        end else if (32'(hnd_q) >= ENTRIES || !used_q[hnd_q[EW-1:0]]) begin
          st_d = ST_BAD; rh_d = hnd_q; rc_d = '0;
          res_v_d = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_REL_WT;
        end
      end
      S_REL_WT: begin
        ent_d = en_rdata;
        state_d = S_REL_DEC;
      end
      S_REL_DEC: begin
        if (ent_q.refs == '0) begin
          st_d = ST_BAD; rh_d = hnd_q; rc_d = '0;
          res_v_d = 1'b1;
          state_d = S_DONE;
        end else if (ent_q.refs != REF_BITS'(1)) begin
          en_we         = 1'b1;
          en_wdata.refs = ent_q.refs - 1'b1;
          st_d = ST_KEPT; rh_d = hnd_q; rc_d = ent_q.refs - 1'b1;
          res_v_d = 1'b1;
          state_d = S_DONE;
        end else begin
          // free the entry and start unlinking
          en_we          = 1'b1;
          en_wdata.valid = 1'b0;
          en_wdata.user  = '0;
          en_wdata.refs  = '0;
          en_wdata.next  = NIL;
          en_wdata.prev  = NIL;
          used_d[cur_q[EW-1:0]] = 1'b0;
          bkt_d   = hash_f(ent_q.user);
          state_d = S_UNL_NEXT;
        end
      end
      // next entry: its prev takes our prev; read it first
      S_UNL_NEXT: begin
        en_addr = ent_q.next[EW-1:0];
        state_d = S_UNL_PREV;
      end
      S_UNL_PREV: begin
        if (ent_q.next < NIL) begin
          en_addr       = ent_q.next[EW-1:0];
          en_we         = 1'b1;
          en_wdata      = en_rdata;
          en_wdata.prev = ent_q.prev;
        end
        state_d = S_UNL_PREV_WT;
      end
      S_UNL_PREV_WT: begin
        en_addr = ent_q.prev[EW-1:0];
        state_d = S_UNL_FIX;
      end
      S_UNL_FIX: begin
        if (ent_q.prev < NIL) begin
          en_addr       = ent_q.prev[EW-1:0];
          en_we         = 1'b1;
          en_wdata      = en_rdata;
          en_wdata.next = ent_q.next;
        end else begin
          bh_we    = 1'b1;
          bh_wdata = ent_q.next;
        end
        st_d = ST_REMOVED; rh_d = hnd_q; rc_d = '0;
        res_v_d = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign done_o          = res_v_q;
  assign status_o        = st_q;
  assign result_handle_o = rh_q;
  assign ref_count_o     = rc_q;

`ifndef ASSERT_OFF
  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result word without work");
  a_no_start_while_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("idle while result word shown");
  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_REMOVED || status_o == ST_FULL)) |-> ref_count_o == '0)
    else $error("removed or full with nonzero count");
  a_created_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_CREATED) |-> ref_count_o == 16'd1)
    else $error("created entry count not one");
`endif

endmodule
`default_nettype wire

@@ sim/rut_checker.sv @@
`default_nettype none
module rut_checker
  import rut_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        operation_i,
  input  wire logic [15:0] user_id_i,
  input  wire logic [5:0]  entry_handle_i,
  input  wire logic        handle_present_i,
  input  wire logic        done_o,
  input  wire logic [2:0]  status_o,
  input  wire logic [5:0]  result_handle_o,
  input  wire logic [15:0] ref_count_o,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 64;
  localparam int NUM_BUCKETS = 256;
  localparam logic [6:0] NIL = 7'd64;

  typedef struct packed {
    status_e     st;
    logic [5:0]  handle;
    logic [15:0] count;
  } answer_t;

  logic [6:0]  head_q  [NUM_BUCKETS];
  logic        live_q  [NUM_ENTRIES];
  logic [15:0] owner_q [NUM_ENTRIES];
  logic [15:0] refs_q  [NUM_ENTRIES];
  logic [6:0]  next_q  [NUM_ENTRIES];
  logic [6:0]  prev_q  [NUM_ENTRIES];

  answer_t answers_due[$];
  int      fails;

  function automatic logic [7:0] bucket_of(logic [15:0] uid);
    return uid[15:8] ^ uid[7:0];
  endfunction

  task automatic link_entry(logic [6:0] e, logic [7:0] b);
    logic [6:0] h;
    h = head_q[b];
    next_q[e] = h;
    if (h < NIL) prev_q[h] = e;
    prev_q[e] = NIL;
    head_q[b] = e;
  endtask

  task automatic unlink_entry(logic [6:0] e);
    logic [6:0] n;
    logic [6:0] p;
    n = next_q[e];
    p = prev_q[e];
    if (n < NIL) prev_q[n] = p;
    if (p < NIL) next_q[p] = n;
    else head_q[bucket_of(owner_q[e])] = n;
    next_q[e] = NIL;
    prev_q[e] = NIL;
  endtask

  task automatic clear_table();
    for (int i = 0; i < NUM_BUCKETS; i++) head_q[i] = NIL;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      live_q[i] = 1'b0;
      owner_q[i] = '0;
      refs_q[i] = '0;
      next_q[i] = NIL;
      prev_q[i] = NIL;
    end
    live_q[0] = 1'b1;
    refs_q[0] = 16'd1;
    link_entry(7'd0, bucket_of(16'd0));
  endtask

  task automatic predict_word(logic op, logic [15:0] uid, logic [5:0] h, logic hp,
                              output answer_t a);
    logic [6:0] cur;
    logic [6:0] hit;
    int         free_idx;
    hit = NIL;
    free_idx = NUM_ENTRIES;
    a = '{st: ST_IGNORED, handle: '0, count: '0};
    if (op_e'(op) == OP_ACQUIRE) begin
      cur = head_q[bucket_of(uid)];
      for (int s = 0; s < NUM_ENTRIES && cur < NIL && hit == NIL; s++) begin
        if (live_q[cur] && owner_q[cur] == uid) hit = cur;
        else cur = next_q[cur];
      end
      if (hit < NIL) begin
        if (refs_q[hit] == REF_MAX) begin
          a = '{st: ST_SAT, handle: hit[5:0], count: REF_MAX};
        end else begin
          refs_q[hit]++;
          a = '{st: ST_FOUND, handle: hit[5:0], count: refs_q[hit]};
        end
      end else begin
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) if (!live_q[i]) free_idx = i;
        if (free_idx == NUM_ENTRIES) begin
          a = '{st: ST_FULL, handle: '0, count: '0};
        end else begin
          live_q[free_idx] = 1'b1;
          owner_q[free_idx] = uid;
          refs_q[free_idx] = 16'd1;
          link_entry(free_idx[6:0], bucket_of(uid));
          a = '{st: ST_CREATED, handle: free_idx[5:0], count: 16'd1};
        end
      end
    end else if (!hp) begin
      a = '{st: ST_IGNORED, handle: '0, count: '0};
    end else if (!live_q[h] || refs_q[h] == 0) begin
      a = '{st: ST_BAD, handle: h, count: '0};
    end else begin
      refs_q[h]--;
      if (refs_q[h] == 0) begin
        unlink_entry({1'b0, h});
        live_q[h] = 1'b0;
        owner_q[h] = '0;
        a = '{st: ST_REMOVED, handle: h, count: '0};
      end else begin
        a = '{st: ST_KEPT, handle: h, count: refs_q[h]};
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t a;
    answer_t want;
    if (!rst_ni) begin
      clear_table();
      answers_due.delete();
    end else begin
      // results first: the queue order is unaffected by a same-edge accept
      if (done_o) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected word: status %0d handle %0d count %0d",
                   $time, status_o, result_handle_o, ref_count_o);
          fails++;
        end else begin
          want = answers_due.pop_front();
          if (status_o != want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
            fails++;
          end
          if (result_handle_o != want.handle) begin
            $display("%0t: handle expected %0d actual %0d",
                     $time, want.handle, result_handle_o);
            fails++;
          end
          if (ref_count_o != want.count) begin
            $display("%0t: count expected %0d actual %0d", $time, want.count, ref_count_o);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        predict_word(operation_i, user_id_i, entry_handle_i, handle_present_i, a);
        answers_due.push_back(a);
      end
    end
  end

  initial fails = 0;
  assign fail_count_o = fails;
  assign pending_o = answers_due.size();
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none
module tb_top
  import rut_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        operation_i = 1'b0;
  logic [15:0] user_id_i = '0;
  logic [5:0]  entry_handle_i = '0;
  logic        handle_present_i = 1'b0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [5:0]  result_handle_o;
  logic [15:0] ref_count_o;
  int          fail_count;
  int          pending;

  // sender idle chance in percent, changed per phase
  int          idle_pct = 0;
  logic [15:0] uid_pool[80];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  refcounted_uid_table u_top (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .user_id_i, .entry_handle_i,
    .handle_present_i, .done_o, .status_o, .result_handle_o, .ref_count_o
  );

  rut_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .user_id_i, .entry_handle_i,
    .handle_present_i, .done_o, .status_o, .result_handle_o, .ref_count_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // hand one word over: busy is read at the falling edge, where it is settled,
  // and start is moved only at rising edges
  task automatic send_word(op_e op, logic [15:0] uid, logic [5:0] h, logic hp);
    while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    start <= 1'b1;
    operation_i <= op;
    user_id_i <= uid;
    entry_handle_i <= h;
    handle_present_i <= hp;
    // busy rises at the edge that takes the word
    do @(negedge clk_i); while (!busy);
    @(posedge clk_i);
    start <= 1'b0;
  endtask

  task automatic acquire(logic [15:0] uid);
    send_word(OP_ACQUIRE, uid, 6'($urandom_range(63)), 1'($urandom_range(1)));
  endtask

  task automatic release_entry(logic [5:0] h, logic hp);
    send_word(OP_RELEASE, 16'($urandom_range(65535)), h, hp);
  endtask

  initial begin
    logic [7:0] hi;
    logic [1:0] b;
    int         pick;
    // pool crowded into four buckets so chains grow long and unlink in the middle
    for (int i = 0; i < 80; i++) begin
      hi = 8'($urandom_range(255));
      b = 2'($urandom_range(3));
      uid_pool[i] = {hi, hi ^ {6'd0, b}};
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // room for the clearing pass after reset
    repeat (300) @(posedge clk_i);

    // directed: root entry, collisions in bucket zero, null and bad handles
    acquire(16'h0000);
    release_entry(6'd0, 1'b1);
    release_entry(6'd0, 1'b1);
    release_entry(6'd0, 1'b1);
    acquire(16'h0101);
    acquire(16'h0000);
    acquire(16'h0101);
    acquire(16'hFFFF);
    release_entry(6'd1, 1'b1);
    release_entry(6'd63, 1'b0);
    release_entry(6'd63, 1'b1);
    acquire(16'hFF00);
    acquire(16'h0000);
    // fill the table until it reports full
    for (int i = 0; i < 64; i++) acquire(16'h2000 + 16'(i));
    for (int i = 0; i < 64; i++) release_entry(6'(i), 1'b1);

    // random phases, mostly pooled uids, releases mostly with a handle
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 60 : (ph == 3) ? 25 : 0;
      for (int n = 0; n < 250; n++) begin
        pick = $urandom_range(99);
        if (pick < 50) acquire(uid_pool[$urandom_range(79)]);
        else if (pick < 55) acquire(16'($urandom_range(65535)));
        else release_entry(6'($urandom_range(63)), $urandom_range(9) != 0);
      end
    end

    idle_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("refcounted_uid_table verification clean");
    end else begin
      $display("refcounted_uid_table verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("refcounted_uid_table verification failed");
    $finish;
  end
endmodule
`default_nettype wire
